// File: hw/rtl/rational_arithmetic_unit_defines.svh
// Assertion macros shared by the rational arithmetic unit RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the rational arithmetic unit.
// No dependencies; imported by every module of the block.
package rau_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int CMD_W     = 2;
	localparam int OPND_W    = 32;
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_COMB2,
		S_ZCHK,
		S_TWOS,
		S_GCD,
		S_SCALE,
		S_DIV,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic take;
		cmd_t cmd;
		logic s1;
		logic s2;
	} core_req_t;

	typedef struct packed {
		logic    idle;
		logic    done;
		status_t status;
		logic    neg;
	} core_rsp_t;

endpackage

// File: hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: operand split, handshakes, result register.
// Depends on rau_pkg, rau_core and the assertion macro header.
//
//   channel   signals                                          direction
//   op        op_valid, op_stall, cmd, first_num, first_den,   in
//             second_num, second_den
//   res       res_valid, res_stall, result_num, result_den,     out
//             status
//
// One operation at a time. An error on the operands sends the sequencer straight to
// its done state, where it waits until the result register can load. Otherwise an item
// passes the multiplies, the combine, the binary gcd (one shift, subtract or swap per
// cycle) and two restoring divides. The combine, the gcd and the divides share one
// adder/subtractor. Reset clears the sequencer and the result valid flag. A stalled
// result waits in its register while the next operation is taken and worked on.
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_stall,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [OPND_W-1:0]    first_num,
	input  logic [OPND_W-1:0]    first_den,
	input  logic [OPND_W-1:0]    second_num,
	input  logic [OPND_W-1:0]    second_den,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [RES_NUM_W-1:0] result_num,
	output logic [RES_DEN_W-1:0] result_den,
	output logic [STATUS_W-1:0]  status
);

	logic [WIDTH-1:0] fn_raw, fd_raw, sn_raw, sd_raw;
	logic [WIDTH-1:0] fn_mag, fd_mag, sn_mag, sd_mag;
	core_req_t        req;
	core_rsp_t        rsp;
	logic [WIDTH-1:0] res_mag;
	logic [WIDTH-2:0] res_den;
	logic             take, load;
	logic [RES_NUM_W-1:0] mag_ext, num_val;

	logic                 res_valid_q;
	logic [RES_NUM_W-1:0] result_num_q;
	logic [RES_DEN_W-1:0] result_den_q;
	status_t              status_q;

	// Only the low WIDTH bits of each operand count, read as two's complement.
	assign fn_raw = first_num[WIDTH-1:0];
	assign fd_raw = first_den[WIDTH-1:0];
	assign sn_raw = second_num[WIDTH-1:0];
	assign sd_raw = second_den[WIDTH-1:0];

	assign fn_mag = fn_raw[WIDTH-1] ? (~fn_raw + WIDTH'(1)) : fn_raw;
	assign fd_mag = fd_raw[WIDTH-1] ? (~fd_raw + WIDTH'(1)) : fd_raw;
	assign sn_mag = sn_raw[WIDTH-1] ? (~sn_raw + WIDTH'(1)) : sn_raw;
	assign sd_mag = sd_raw[WIDTH-1] ? (~sd_raw + WIDTH'(1)) : sd_raw;

	assign take      = !res_valid_q || !res_stall;
	assign load      = rsp.done && take;
	assign op_stall  = !rsp.idle;

	assign req.start = op_valid && rsp.idle;
	assign req.take  = take;
	assign req.cmd   = cmd_t'(cmd);
	assign req.s1    = fn_raw[WIDTH-1] ^ fd_raw[WIDTH-1];
	assign req.s2    = sn_raw[WIDTH-1] ^ sd_raw[WIDTH-1];

	rau_core #(.WIDTH(WIDTH)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.n1      (fn_mag),
		.d1      (fd_mag),
		.n2      (sn_mag),
		.d2      (sd_mag),
		.rsp     (rsp),
		.res_mag (res_mag),
		.res_den (res_den)
	);

	assign mag_ext = RES_NUM_W'(res_mag);
	assign num_val = rsp.neg ? (~mag_ext + RES_NUM_W'(1)) : mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= rsp.status;
			if (rsp.status == ST_OK) begin
				result_num_q <= num_val;
				result_den_q <= RES_DEN_W'(res_den);
			end else begin
				result_num_q <= '0;
				result_den_q <= '0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign result_num = result_num_q;
	assign result_den = result_den_q;
	assign status     = status_q;

	`RAU_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, op_valid && !op_stall, op_stall,
		"operand beat taken without the sequencer going busy")
	`RAU_ASSERT_IMPL(a_err_zero_fields, clk, arst_n,
		res_valid_q && (status_q != ST_OK),
		(result_num_q == '0) && (result_den_q == '0),
		"error result with nonzero fields")
	`RAU_ASSERT_IMPL(a_ok_den_positive, clk, arst_n,
		res_valid_q && (status_q == ST_OK), result_den_q != '0,
		"good result with a zero denominator")

endmodule

// File: hw/rtl/rau_mul.sv
`timescale 1ns / 1ps
// Unsigned multiplier with a registered product, shared by the sequencer.
// Depends on rau_pkg for the default width.
module rau_mul import rau_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                 clk,
	input  logic [WIDTH-1:0]     x,
	input  logic [WIDTH-1:0]     y,
	output logic [2*WIDTH-1:0]   p
);

	logic [2*WIDTH-1:0] prod;
	logic [2*WIDTH-1:0] p_q;

	assign prod = x * y;

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

	assign p = p_q;

endmodule

// File: hw/rtl/rau_alu.sv
`timescale 1ns / 1ps
// Shared adder/subtractor with borrow output for the rational arithmetic unit.
// Depends on rau_pkg for the default width.
module rau_alu import rau_pkg::*; #(
	parameter int AW = 2 * WIDTH_DEF + 1
) (
	input  logic [AW-1:0] x,
	input  logic [AW-1:0] y,
	input  logic          sub,
	output logic [AW-1:0] r,
	output logic          borrow
);

	logic [AW:0] sum;
	logic [AW-1:0] y_op;

	assign y_op   = sub ? ~y : y;
	assign sum    = {1'b0, x} + {1'b0, y_op} + {{AW{1'b0}}, sub};
	assign r      = sum[AW-1:0];
	// With subtraction a missing carry out means x < y.
	assign borrow = sub & ~sum[AW];

endmodule

// File: hw/rtl/rau_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath: cross products, combine, binary gcd, exact divides.
// Depends on rau_pkg, rau_mul, rau_alu and the assertion macro header.
`include "rational_arithmetic_unit_defines.svh"

module rau_core import rau_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  core_req_t        req,
	input  logic [WIDTH-1:0] n1,
	input  logic [WIDTH-1:0] d1,
	input  logic [WIDTH-1:0] n2,
	input  logic [WIDTH-1:0] d2,
	output core_rsp_t        rsp,
	output logic [WIDTH-1:0] res_mag,
	output logic [WIDTH-2:0] res_den
);

	localparam int DW = 2 * WIDTH;
	localparam int AW = DW + 1;
	localparam int KW = $clog2(DW);

	state_t state_q, state_d;

	cmd_t             cmd_q;
	logic             s1_q, s2_q, neg_q;
	logic [WIDTH-1:0] n1_q, d1_q, n2_q, d2_q;
	logic [DW-1:0]    a_q, b_q, mag_q, den_q, u_q, v_q, rem_q, quo_q;
	logic [KW-1:0]    k_q, cnt_q;
	logic             sel_q;
	status_t          status_q;

	logic             sb, is_addsub, in_err, ovf;
	logic [WIDTH-1:0] mul_x, mul_y;
	logic [DW-1:0]    mul_p;
	logic [AW-1:0]    alu_x, alu_y, alu_r;
	logic             alu_sub, alu_borrow;
	logic [AW-1:0]    shifted;
	logic [DW-1:0]    quo_next;

	rau_mul #(.WIDTH(WIDTH)) u_mul (
		.clk (clk),
		.x   (mul_x),
		.y   (mul_y),
		.p   (mul_p)
	);

	rau_alu #(.AW(AW)) u_alu (
		.x      (alu_x),
		.y      (alu_y),
		.sub    (alu_sub),
		.r      (alu_r),
		.borrow (alu_borrow)
	);

	assign sb        = (cmd_q == CMD_SUB) ? ~s2_q : s2_q;
	assign is_addsub = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);
	assign in_err    = (d1 == '0) || (d2 == '0) || ((req.cmd == CMD_DIV) && (n2 == '0));
	assign shifted   = {rem_q, quo_q[DW-1]};
	assign quo_next  = {quo_q[DW-2:0], ~alu_borrow};

	// The reduced fraction must fit a signed WIDTH-bit numerator and a positive
	// denominator below 2^(WIDTH-1).
	assign ovf = (|den_q[DW-1:WIDTH-1]) ||
		(neg_q ? ((|mag_q[DW-1:WIDTH]) || (mag_q[WIDTH-1] && (|mag_q[WIDTH-2:0])))
		       : (|mag_q[DW-1:WIDTH-1]));

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			S_MUL0: begin
				mul_x = n1_q;
				mul_y = (cmd_q == CMD_MUL) ? n2_q : d2_q;
			end
			S_MUL1: begin
				mul_x = n2_q;
				mul_y = d1_q;
			end
			S_MUL2: begin
				mul_x = d1_q;
				mul_y = (cmd_q == CMD_DIV) ? n2_q : d2_q;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	always_comb begin
		alu_x   = '0;
		alu_y   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_COMB: begin
				alu_x   = {1'b0, a_q};
				alu_y   = {1'b0, b_q};
				alu_sub = (s1_q != sb);
			end
			S_COMB2: begin
				alu_x   = {1'b0, b_q};
				alu_y   = {1'b0, a_q};
				alu_sub = 1'b1;
			end
			S_GCD: begin
				alu_x   = {1'b0, v_q};
				alu_y   = {1'b0, u_q};
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_x   = shifted;
				alu_y   = {1'b0, u_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_x   = '0;
				alu_y   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rsp.idle   = (state_q == S_IDLE);
		rsp.done   = (state_q == S_DONE);
		rsp.status = status_q;
		rsp.neg    = neg_q;
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					state_d = in_err ? S_DONE : S_MUL0;
				end
			end
			S_MUL0:  state_d = S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_MUL3;
			S_MUL3:  state_d = S_COMB;
			S_COMB: begin
				if (is_addsub && alu_sub && alu_borrow) begin
					state_d = S_COMB2;
				end else begin
					state_d = S_ZCHK;
				end
			end
			S_COMB2: state_d = S_ZCHK;
			S_ZCHK: begin
				state_d = (mag_q == '0) ? S_CHECK : S_TWOS;
			end
			S_TWOS: begin
				if (u_q[0] || v_q[0]) begin
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (v_q == '0) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				if (k_q == '0) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if ((cnt_q == '0) && sel_q) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = S_DONE;
			S_DONE: begin
				if (req.take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Counters and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			cnt_q    <= '0;
			sel_q    <= 1'b0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						status_q <= in_err ? ST_ZERO_DEN : ST_OK;
						k_q      <= '0;
					end
				end
				S_TWOS: begin
					if (!(u_q[0] || v_q[0])) begin
						k_q <= k_q + KW'(1);
					end
				end
				S_SCALE: begin
					if (k_q != '0) begin
						k_q <= k_q - KW'(1);
					end else begin
						cnt_q <= KW'(DW - 1);
						sel_q <= 1'b0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - KW'(1);
					if ((cnt_q == '0) && !sel_q) begin
						sel_q <= 1'b1;
						cnt_q <= KW'(DW - 1);
					end
				end
				S_CHECK: begin
					status_q <= ovf ? ST_OVERFLOW : ST_OK;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					cmd_q <= req.cmd;
					s1_q  <= req.s1;
					s2_q  <= req.s2;
					n1_q  <= n1;
					d1_q  <= d1;
					n2_q  <= n2;
					d2_q  <= d2;
				end
			end
			S_MUL1: a_q   <= mul_p;
			S_MUL2: b_q   <= mul_p;
			S_MUL3: den_q <= mul_p;
			S_COMB: begin
				if (!is_addsub) begin
					mag_q <= a_q;
					neg_q <= s1_q ^ s2_q;
				end else begin
					// On a borrow the magnitude is redone as b - a in the next cycle.
					mag_q <= alu_r[DW-1:0];
					neg_q <= (alu_sub && alu_borrow) ? sb : s1_q;
				end
			end
			S_COMB2: mag_q <= alu_r[DW-1:0];
			S_ZCHK: begin
				if (mag_q == '0) begin
					den_q <= DW'(1);
					neg_q <= 1'b0;
				end else begin
					u_q <= mag_q;
					v_q <= den_q;
				end
			end
			S_TWOS: begin
				if (!(u_q[0] || v_q[0])) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
				end
			end
			S_GCD: begin
				if (v_q != '0) begin
					if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (alu_borrow) begin
						// Keep u below v so that the difference never goes negative.
						u_q <= v_q;
						v_q <= u_q;
					end else begin
						v_q <= alu_r[DW-1:0];
					end
				end
			end
			S_SCALE: begin
				if (k_q != '0) begin
					u_q <= u_q << 1;
				end else begin
					rem_q <= '0;
					quo_q <= mag_q;
				end
			end
			S_DIV: begin
				rem_q <= alu_borrow ? shifted[DW-1:0] : alu_r[DW-1:0];
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					if (!sel_q) begin
						mag_q <= quo_next;
						rem_q <= '0;
						quo_q <= den_q;
					end else begin
						den_q <= quo_next;
					end
				end
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign res_mag = mag_q[WIDTH-1:0];
	assign res_den = den_q[WIDTH-2:0];

	`RAU_ASSERT_IMPL(a_start_when_idle, clk, arst_n, req.start, state_q == S_IDLE,
		"operation started while the sequencer is busy")
	`RAU_ASSERT_IMPL(a_gcd_one_odd, clk, arst_n, state_q == S_GCD, u_q[0] || v_q[0],
		"gcd loop entered with both operands even")
	`RAU_ASSERT_IMPL(a_div_nonzero, clk, arst_n, state_q == S_DIV, u_q != '0,
		"division by a zero gcd")
	`RAU_ASSERT_IMPL(a_ok_den_nonzero, clk, arst_n,
		(state_q == S_DONE) && (status_q == ST_OK), den_q != '0,
		"good result with a zero denominator")

endmodule
